/* rtl/core/fdsp_pkg.sv */
// Shared types and constants of the decimal stream formatter.
package fdsp_pkg;

   localparam int MAX_DIGITS     = 10;
   localparam int COUNT_BITS     = 16;
   localparam int ARG_BITS       = 31;
   localparam int BCD_BITS       = 4 * MAX_DIGITS;
   localparam int DIGIT_CNT_BITS = $clog2(MAX_DIGITS + 1);
   localparam int BIT_CNT_BITS   = $clog2(ARG_BITS + 1);

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_D       = 8'h64;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;

   typedef struct packed {
      logic [7:0]          format_char;
      logic [ARG_BITS-1:0] argument;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        last_of_run;
      logic [15:0] emitted_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift_digit;
   } conv_cmd_type;

   typedef struct packed {
      logic       done;
      logic       ovf;
      logic [3:0] top_digit;
   } conv_stat_type;

   typedef struct packed {
      logic       push;
      logic [7:0] out_char;
      logic       last;
   } out_push_type;

endpackage

/* rtl/core/fdsp_bcd_conv.sv */
// Bit-serial binary to BCD converter with a digit-wide output shifter.
module fdsp_bcd_conv (
   input  logic                           clock,
   input  logic                           reset,
   input  fdsp_pkg::conv_cmd_type         cmd,
   input  logic [fdsp_pkg::ARG_BITS-1:0]  arg,
   output fdsp_pkg::conv_stat_type        stat
);

   logic [fdsp_pkg::ARG_BITS-1:0]     bin_ff, bin_in;
   logic [fdsp_pkg::BCD_BITS-1:0]     bcd_ff, bcd_in, bcd_adj;
   logic                              ovf_ff, ovf_in;
   logic [fdsp_pkg::BIT_CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      for (int i = 0; i < fdsp_pkg::MAX_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         bin_in = arg;
         bcd_in = '0;
         ovf_in = 1'b0;
         cnt_in = fdsp_pkg::BIT_CNT_BITS'(fdsp_pkg::ARG_BITS);
      end else if (cnt_ff != '0) begin
         bcd_in = {bcd_adj[fdsp_pkg::BCD_BITS-2:0], bin_ff[fdsp_pkg::ARG_BITS-1]};
         ovf_in = ovf_ff | bcd_adj[fdsp_pkg::BCD_BITS-1];
         bin_in = {bin_ff[fdsp_pkg::ARG_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end else if (cmd.shift_digit) begin
         bcd_in = {bcd_ff[fdsp_pkg::BCD_BITS-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      ovf_ff <= ovf_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign stat.done      = (cnt_ff == '0);
   assign stat.ovf       = ovf_ff;
   assign stat.top_digit = bcd_ff[fdsp_pkg::BCD_BITS-1 -: 4];

endmodule

/* rtl/core/fdsp_out_stage.sv */
// Result register with the saturating count of emitted characters.
module fdsp_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  fdsp_pkg::out_push_type push,
   output logic                   can_take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fdsp_pkg::rsp_type      rsp_data
);

   localparam logic [fdsp_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

   logic                            valid_ff;
   logic [fdsp_pkg::COUNT_BITS-1:0] total_ff, total_in;
   logic [fdsp_pkg::COUNT_BITS+15:0] total_wide;
   fdsp_pkg::rsp_type               data_ff;

   assign total_in   = (total_ff == COUNT_MAX) ? total_ff : total_ff + 1'b1;
   assign total_wide = {16'd0, total_in};
   assign can_take   = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
      end else if (push.push) begin
         valid_ff <= 1'b1;
         total_ff <= total_in;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (push.push) begin
         data_ff.out_char      <= push.out_char;
         data_ff.last_of_run   <= push.last;
         data_ff.emitted_count <= total_wide[15:0];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/core/format_decimal_stream_printer_unit.sv */
// Top level of the decimal stream formatter: sequencing of echo and %d output.
//
// Each request transaction carries one format byte and an integer argument.
// An ordinary byte is echoed as one response transaction in the cycle after
// it is accepted. A '%' produces nothing and arms a pending flag; a following
// 'd' prints the argument in decimal, most significant digit first, with
// last_of_run set on the final digit (an echoed byte also has it set). Any
// other byte after '%' is dropped. emitted_count reports the saturating total
// of characters sent so far. An echoed, percent or dropped byte leaves the
// block idle, ready for the next request once the response register has room.
// A %d passes through the accept, the converter state (31 shift steps and a
// check that the bit count reached zero), the skip state, which drops leading
// zeros, and the emit state, which sends a digit whenever the response
// register has room; skipped zeros and digits always add up to ten. No new
// request is accepted until the last digit has gone into the response register.
// Reset clears the pending flag, the character count and the response valid.
// When the receiver stalls, the single response register holds its
// transaction and the block waits.
module format_decimal_stream_printer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fdsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fdsp_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic                               pending_ff, pending_in;
   logic [fdsp_pkg::DIGIT_CNT_BITS-1:0] remain_ff, remain_in;

   fdsp_pkg::conv_cmd_type  cmd;
   fdsp_pkg::conv_stat_type stat;
   fdsp_pkg::out_push_type  push;
   logic                    can_take;
   logic                    req_acc;

   fdsp_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .arg   (req_data.argument),
      .stat  (stat)
   );

   fdsp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign req_ready = (state_ff == ST_IDLE) && can_take;
   assign req_acc   = req_valid && req_ready;

   always_comb begin
      state_in         = state_ff;
      pending_in       = pending_ff;
      remain_in        = remain_ff;
      cmd.load         = 1'b0;
      cmd.shift_digit  = 1'b0;
      push.push        = 1'b0;
      push.out_char    = req_data.format_char;
      push.last        = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!pending_ff) begin
                  if (req_data.format_char == fdsp_pkg::CHAR_PERCENT) begin
                     pending_in = 1'b1;
                  end else begin
                     push.push = 1'b1;
                  end
               end else begin
                  pending_in = 1'b0;
                  if (req_data.format_char == fdsp_pkg::CHAR_D) begin
                     cmd.load = 1'b1;
                     state_in = ST_CONV;
                  end
               end
            end
         end
         ST_CONV: begin
            remain_in = fdsp_pkg::DIGIT_CNT_BITS'(fdsp_pkg::MAX_DIGITS);
            if (stat.done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (stat.top_digit == 4'd0 && !stat.ovf && remain_ff > 1) begin
               cmd.shift_digit = 1'b1;
               remain_in       = remain_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            push.out_char = fdsp_pkg::CHAR_ZERO + {4'd0, stat.top_digit};
            push.last     = (remain_ff == 1);
            if (can_take) begin
               push.push       = 1'b1;
               cmd.shift_digit = 1'b1;
               remain_in       = remain_ff - 1'b1;
               if (remain_ff == 1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= 1'b0;
         remain_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         remain_ff  <= remain_in;
      end
   end

   a_d_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_acc && pending_ff && req_data.format_char == fdsp_pkg::CHAR_D)
      |=> (state_ff == ST_CONV))
      else $error("conversion did not start after a %%d");

   a_emit_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (remain_ff != '0))
      else $error("digit emission with no digits left");

   a_pending_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(pending_ff) |-> $past(req_acc && req_data.format_char == fdsp_pkg::CHAR_PERCENT))
      else $error("pending flag set without a percent byte");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.push |-> can_take)
      else $error("response pushed while the output register is full");

endmodule

/* tb/fdsp_stream_checker.sv */
// Checker that predicts the formatter's printed characters and compares each response.
`timescale 1ns / 100ps

module fdsp_stream_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  fdsp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  fdsp_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                expected_left
);

   logic                            percent_armed;
   logic [fdsp_pkg::COUNT_BITS-1:0] printed_total;
   fdsp_pkg::rsp_type               expected_chars[$];

   task automatic report_mismatch(input string message);
      $display("%0t ns: %s", $time, message);
      error_count++;
   endtask

   function automatic void push_char(input logic [7:0] char_code, input logic last_char);
      fdsp_pkg::rsp_type entry;
      if (printed_total != {fdsp_pkg::COUNT_BITS{1'b1}})
         printed_total++;
      entry.out_char      = char_code;
      entry.last_of_run   = last_char;
      entry.emitted_count = 16'(printed_total);
      expected_chars.push_back(entry);
   endfunction

   task automatic predict_printed_chars(input fdsp_pkg::req_type item);
      logic [fdsp_pkg::ARG_BITS-1:0] value;
      logic [3:0]                    digit_list [fdsp_pkg::MAX_DIGITS];
      int                            digit_count;
      value       = item.argument;
      digit_count = 0;
      if (!percent_armed) begin
         if (item.format_char == fdsp_pkg::CHAR_PERCENT)
            percent_armed = 1'b1;
         else
            push_char(item.format_char, 1'b1);
      end else begin
         percent_armed = 1'b0;
         if (item.format_char == fdsp_pkg::CHAR_D) begin
            do begin
               digit_list[digit_count] = 4'(value % 10);
               value = value / 10;
               digit_count++;
            end while (value != 0 && digit_count < fdsp_pkg::MAX_DIGITS);
            for (int i = digit_count - 1; i >= 0; i--)
               push_char(fdsp_pkg::CHAR_ZERO + 8'(digit_list[i]), i == 0);
         end
      end
   endtask

   always @(posedge clock) begin
      fdsp_pkg::rsp_type wanted;
      if (reset) begin
         percent_armed = 1'b0;
         printed_total = '0;
         expected_chars.delete();
      end else begin
         if (req_valid && req_ready)
            predict_printed_chars(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction with character %02h",
                                         rsp_data.out_char));
            end else begin
               wanted = expected_chars.pop_front();
               if (rsp_data.out_char !== wanted.out_char)
                  report_mismatch($sformatf("out_char %02h, expected %02h",
                                            rsp_data.out_char, wanted.out_char));
               if (rsp_data.last_of_run !== wanted.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, expected %b",
                                            rsp_data.last_of_run, wanted.last_of_run));
               if (rsp_data.emitted_count !== wanted.emitted_count)
                  report_mismatch($sformatf("emitted_count %0d, expected %0d",
                                            rsp_data.emitted_count, wanted.emitted_count));
            end
         end
      end
      expected_left <= expected_chars.size();
   end

endmodule

/* tb/tb_format_decimal_stream_printer_unit.sv */
// Testbench top of the decimal stream formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_format_decimal_stream_printer_unit;

   localparam int QUIET_LIMIT    = 2000;
   localparam int HOLD_OFF_TICKS = 300;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   fdsp_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   fdsp_pkg::rsp_type rsp_data;

   int error_count;
   int expected_left;
   int items_sent;
   int quiet_cycles;
   bit steady_phase;
   bit hold_off_request;

   format_decimal_stream_printer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   fdsp_stream_checker stream_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .expected_left (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_TICKS) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (steady_phase) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 37);
         end
      end
   end

   task automatic send_format_byte(input logic [7:0] char_code,
                                   input logic [fdsp_pkg::ARG_BITS-1:0] value);
      if (!steady_phase && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{format_char: char_code, argument: value};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_plain_char();
      logic [7:0] char_code;
      do char_code = 8'($urandom_range(0, 255)); while (char_code == fdsp_pkg::CHAR_PERCENT);
      return char_code;
   endfunction

   function automatic logic [fdsp_pkg::ARG_BITS-1:0] pick_argument();
      longint unsigned low_bound;
      longint unsigned high_bound;
      int              digits;
      low_bound = 1;
      case ($urandom_range(0, 3))
         0: return fdsp_pkg::ARG_BITS'($urandom_range(0, 9));
         1: return fdsp_pkg::ARG_BITS'($urandom());
         default: begin
            digits = $urandom_range(1, 10);
            repeat (digits - 1) low_bound = low_bound * 10;
            high_bound = low_bound * 10 - 1;
            if (high_bound > 64'h7FFF_FFFF)
               high_bound = 64'h7FFF_FFFF;
            if ($urandom_range(0, 3) == 0)
               return fdsp_pkg::ARG_BITS'($urandom_range(0, 1) ? low_bound : high_bound);
            return fdsp_pkg::ARG_BITS'($urandom_range(32'(high_bound), 32'(low_bound)));
         end
      endcase
   endfunction

   task automatic send_random_sequence();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_format_byte(pick_plain_char(), fdsp_pkg::ARG_BITS'($urandom()));
      end else if (pick < 80) begin
         send_format_byte(fdsp_pkg::CHAR_PERCENT, fdsp_pkg::ARG_BITS'($urandom()));
         send_format_byte(fdsp_pkg::CHAR_D, pick_argument());
      end else if (pick < 90) begin
         send_format_byte(fdsp_pkg::CHAR_PERCENT, fdsp_pkg::ARG_BITS'($urandom()));
         send_format_byte(8'($urandom_range(0, 255)), pick_argument());
      end else begin
         send_format_byte(8'($urandom_range(0, 255)), pick_argument());
      end
   endtask

   task automatic run_random_items(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) send_random_sequence();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_format_byte(8'h00, '0);
      send_format_byte(8'hFF, '1);
      send_format_byte(fdsp_pkg::CHAR_D, 31'd5);
      send_format_byte(fdsp_pkg::CHAR_PERCENT, '1);
      send_format_byte(fdsp_pkg::CHAR_D, '0);
      send_format_byte(fdsp_pkg::CHAR_PERCENT, '0);
      send_format_byte(fdsp_pkg::CHAR_D, 31'h7FFF_FFFF);
      send_format_byte(fdsp_pkg::CHAR_PERCENT, '0);
      send_format_byte(fdsp_pkg::CHAR_D, 31'd1_000_000_000);
      send_format_byte(fdsp_pkg::CHAR_PERCENT, '0);
      send_format_byte(fdsp_pkg::CHAR_PERCENT, 31'd12);
      send_format_byte(8'h78, 31'd3);
      send_format_byte(fdsp_pkg::CHAR_PERCENT, '0);
      send_format_byte(8'h71, 31'd99);
      send_format_byte(fdsp_pkg::CHAR_PERCENT, '0);
      send_format_byte(8'h44, 31'd42);
      send_format_byte(fdsp_pkg::CHAR_PERCENT, '0);
      send_format_byte(fdsp_pkg::CHAR_D, 31'd7);
      send_format_byte(fdsp_pkg::CHAR_PERCENT, '0);
      send_format_byte(fdsp_pkg::CHAR_D, 31'd999_999_999);

      run_random_items(40);
      steady_phase = 1'b1;
      run_random_items(40);
      steady_phase = 1'b0;

      hold_off_request = 1'b1;
      repeat (20) send_format_byte(pick_plain_char(), fdsp_pkg::ARG_BITS'($urandom()));
      wait_for_drain();

      run_random_items(50);

      wait_for_drain();

      run_random_items(30);

      wait_for_drain();
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_left == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
